[hw/rtl/weekly_alarm_scheduler_defines.svh]
// Assertion macros for the weekly alarm scheduler
`ifndef WEEKLY_ALARM_SCHEDULER_DEFINES_SVH
`define WEEKLY_ALARM_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside reset
`define WKAL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Overlapping implication, checked outside reset
`define WKAL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define WKAL_ASSERT(name, prop, msg)
`define WKAL_ASSERT_IMP(name, ante, cons, msg)

`endif

`endif

[hw/rtl/wkal_pkg.sv]
// Types, constants and helpers shared by the weekly alarm scheduler
package wkal_pkg;

   localparam int ENTRIES     = 16;
   localparam int ADDR_W      = $clog2(ENTRIES);
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int OFFSETS     = 8;
   localparam int OFF_W       = $clog2(OFFSETS);
   localparam int DAYS        = 7;
   localparam int SEC_PER_MIN = 60;
   localparam int MIN_PER_HR  = 60;
   localparam int SEC_PER_DAY = 86400;
   localparam int ONE_WEEK    = 604800;
   localparam int DELAY_W     = 20;
   localparam int BASE_W      = 19;
   localparam int T_W         = 21;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_FIRE  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] STATUS_WRITTEN = 2'd0;
   localparam logic [1:0] STATUS_ARMED   = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRE_RD,
      ST_FIRE_CAP,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [6:0] mask;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [7:0] amount;
      logic       enable;
   } entry_type;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] entry_slot;
      logic [6:0] day_mask;
      logic [4:0] entry_hour;
      logic [5:0] entry_minute;
      logic [7:0] entry_amount;
      logic       entry_enable;
      logic [2:0] now_weekday;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         armed_slot;
      logic [DELAY_W-1:0] delay_seconds;
      logic               fired;
      logic [7:0]         fired_amount;
   } rsp_payload_type;

   // weekday plus offset, wrapped into one week; wday is already below DAYS
   function automatic logic [2:0] day_of(input logic [2:0] wday,
                                         input logic [OFF_W-1:0] offs);
      logic [3:0] sum;
      sum = {1'b0, wday} + {1'b0, offs};
      if (sum >= 4'(DAYS)) begin
         sum = sum - 4'(DAYS);
      end
      return sum[2:0];
   endfunction

endpackage

[hw/rtl/wkal_stream_if.sv]
// Valid/ready channel interfaces for the scheduler's command and result beats
interface wkal_req_if
   import wkal_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wkal_rsp_if
   import wkal_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/weekly_alarm_scheduler.sv]
// Weekly alarm scheduler: a table of weekly alarms, searched for the nearest one on a query.
// A query reads entry_count entries (entry_count saturated at the table size): the table sits in a
// single-port memory read one entry per cycle, and every entry is checked against all eight
// day offsets at once in a two-stage pipeline behind the read.
// A fire command first reads the armed entry's amount, in ST_FIRE_RD and ST_FIRE_CAP, before the search. A new
// command is taken while a finished result still waits on the result channel; the next result
// is held until that one has gone. Command 3 is taken and gives no result.
`include "weekly_alarm_scheduler_defines.svh"

module weekly_alarm_scheduler
   import wkal_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   wkal_req_if.sink         req_ch,
   wkal_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);

   entry_type mem [ENTRIES];
   entry_type mem_q_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   state_type state_ff, state_in;

   logic [4:0]        entry_count_ff;
   logic [CNT_W-1:0]  limit;

   logic [1:0]        cmd_ff, cmd_in;
   logic [2:0]        wday_ff, wday_in;
   logic [4:0]        hh_ff, hh_in;
   logic [5:0]        mm_ff, mm_in;
   logic [5:0]        ss_ff, ss_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              v1_ff, v1_in;
   logic [ADDR_W-1:0] idx1_ff, idx1_in;

   logic              v2_ff;
   logic [ADDR_W-1:0] idx2_ff;
   logic [6:0]        mask2_ff;
   logic              en2_ff;
   logic signed [BASE_W-1:0] base_ff, base_in;

   logic              found_ff, found_in;
   logic [OFF_W-1:0]  best_d_ff, best_d_in;
   logic [DELAY_W-1:0] best_t_ff, best_t_in;
   logic [ADDR_W-1:0] pick_ff, pick_in;

   logic              fired_ff, fired_in;
   logic [7:0]        fired_amt_ff, fired_amt_in;

   logic              armed_valid_ff, armed_valid_in;
   logic [ADDR_W-1:0] armed_slot_ff, armed_slot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              req_ready;
   logic              accept;
   logic              start_search;
   logic              load_rsp;

   logic              e_hit;
   logic [OFF_W-1:0]  e_d;
   logic [DELAY_W-1:0] e_t;
   logic              take;

   assign limit = (entry_count_ff > 5'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(entry_count_ff);
   assign accept = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // table memory
   assign rd_addr = (state_ff == ST_FIRE_RD) ? armed_slot_ff : cnt_ff[ADDR_W-1:0];
   assign mem_we  = accept && (req_ch.data.command == CMD_WRITE) &&
                    (int'(req_ch.data.entry_slot) < ENTRIES);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'(req_ch.data.entry_slot)] <= '{mask:   req_ch.data.day_mask,
                                                 hour:   req_ch.data.entry_hour,
                                                 minute: req_ch.data.entry_minute,
                                                 amount: req_ch.data.entry_amount,
                                                 enable: req_ch.data.entry_enable};
      end
      mem_q_ff <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      start_search = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               case (req_ch.data.command)
                  CMD_WRITE: state_in = ST_DONE;
                  CMD_QUERY: begin
                     state_in     = ST_SWEEP;
                     start_search = 1'b1;
                  end
                  CMD_FIRE: begin
                     state_in     = ST_FIRE_RD;
                     start_search = 1'b1;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIRE_RD:  state_in = ST_FIRE_CAP;
         ST_FIRE_CAP: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (cnt_ff >= limit && !v1_ff && !v2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command capture and read issue
   always_comb begin
      cmd_in  = cmd_ff;
      wday_in = wday_ff;
      hh_in   = hh_ff;
      mm_in   = mm_ff;
      ss_in   = ss_ff;
      if (accept) begin
         cmd_in  = req_ch.data.command;
         wday_in = (req_ch.data.now_weekday >= 3'(DAYS)) ? 3'd0 : req_ch.data.now_weekday;
         hh_in   = req_ch.data.now_hour;
         mm_in   = req_ch.data.now_minute;
         ss_in   = req_ch.data.now_second;
      end
      cnt_in  = cnt_ff;
      v1_in   = 1'b0;
      idx1_in = cnt_ff[ADDR_W-1:0];
      if (start_search) begin
         cnt_in = '0;
      end else if (state_ff == ST_SWEEP && cnt_ff < limit) begin
         v1_in  = 1'b1;
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // stage 1: seconds from now to the entry's time on the current day
   always_comb begin
      logic signed [6:0]  hd;
      logic signed [7:0]  md;
      logic signed [11:0] mins;
      hd = signed'({2'b00, mem_q_ff.hour}) - signed'({2'b00, hh_ff});
      md = signed'({2'b00, mem_q_ff.minute}) - signed'({2'b00, mm_ff});
      mins = 12'(hd) * 12'(MIN_PER_HR) + 12'(md);
      base_in = BASE_W'(mins) * BASE_W'(SEC_PER_MIN) - BASE_W'(signed'({1'b0, ss_ff}));
   end

   // stage 2: earliest qualifying day offset for this entry, all offsets in parallel
   always_comb begin
      logic signed [T_W-1:0] t_d;
      logic [2:0]            day;
      e_hit = 1'b0;
      e_d   = '0;
      e_t   = '0;
      for (int d = OFFSETS - 1; d >= 0; d--) begin
         t_d = T_W'(base_ff) + T_W'(d * SEC_PER_DAY);
         day = day_of(wday_ff, OFF_W'(d));
         if (en2_ff && mask2_ff[day] && !t_d[T_W-1] && t_d < T_W'(ONE_WEEK)) begin
            e_hit = 1'b1;
            e_d   = OFF_W'(d);
            e_t   = t_d[DELAY_W-1:0];
         end
      end
   end

   // strict compare keeps the lower index on a tie
   assign take = v2_ff && e_hit &&
                 (!found_ff || e_d < best_d_ff || (e_d == best_d_ff && e_t < best_t_ff));

   always_comb begin
      found_in  = found_ff;
      best_d_in = best_d_ff;
      best_t_in = best_t_ff;
      pick_in   = pick_ff;
      if (start_search) begin
         found_in  = 1'b0;
         best_d_in = '0;
         best_t_in = DELAY_W'(ONE_WEEK);
         pick_in   = '0;
      end else if (take) begin
         found_in  = 1'b1;
         best_d_in = e_d;
         best_t_in = e_t;
         pick_in   = idx2_ff;
      end
   end

   // fire report, armed entry and result beat
   always_comb begin
      fired_in     = fired_ff;
      fired_amt_in = fired_amt_ff;
      if (start_search) begin
         fired_in     = 1'b0;
         fired_amt_in = '0;
      end else if (state_ff == ST_FIRE_CAP && armed_valid_ff) begin
         fired_in     = 1'b1;
         fired_amt_in = mem_q_ff.amount;
      end

      armed_valid_in = armed_valid_ff;
      armed_slot_in  = armed_slot_ff;
      if (load_rsp && cmd_ff != CMD_WRITE) begin
         armed_valid_in = found_ff;
         armed_slot_in  = found_ff ? pick_ff : '0;
      end

      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         if (cmd_ff == CMD_WRITE) begin
            rsp_data_in = '0;
            rsp_data_in.status = STATUS_WRITTEN;
         end else begin
            rsp_data_in.status        = found_ff ? STATUS_ARMED : STATUS_NONE;
            rsp_data_in.armed_slot    = found_ff ? 4'(pick_ff) : 4'd0;
            rsp_data_in.delay_seconds = best_t_ff;
            rsp_data_in.fired         = fired_ff;
            rsp_data_in.fired_amount  = fired_amt_ff;
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         armed_valid_ff <= 1'b0;
         armed_slot_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         cnt_ff         <= '0;
         found_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
         armed_valid_ff <= armed_valid_in;
         armed_slot_ff  <= armed_slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         v1_ff          <= v1_in;
         v2_ff          <= v1_ff;
         cnt_ff         <= cnt_in;
         found_ff       <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      wday_ff      <= wday_in;
      hh_ff        <= hh_in;
      mm_ff        <= mm_in;
      ss_ff        <= ss_in;
      idx1_ff      <= idx1_in;
      idx2_ff      <= idx1_ff;
      mask2_ff     <= mem_q_ff.mask;
      en2_ff       <= mem_q_ff.enable;
      base_ff      <= base_in;
      best_d_ff    <= best_d_in;
      best_t_ff    <= best_t_in;
      pick_ff      <= pick_in;
      fired_ff     <= fired_in;
      fired_amt_ff <= fired_amt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // checks
   `WKAL_ASSERT_IMP(a_arm_at_done, $rose(armed_valid_ff), $past(state_ff == ST_DONE), "armed outside completion")
   `WKAL_ASSERT_IMP(a_pipe_in_sweep, v1_ff || v2_ff, state_ff == ST_SWEEP, "search pipeline busy outside sweep")
   `WKAL_ASSERT_IMP(a_none_full_week, rsp_valid_ff && rsp_data_ff.status == STATUS_NONE, rsp_data_ff.delay_seconds == DELAY_W'(ONE_WEEK) && rsp_data_ff.armed_slot == 4'd0, "no-alarm beat malformed")
   `WKAL_ASSERT_IMP(a_fire_not_write, rsp_valid_ff && rsp_data_ff.fired, rsp_data_ff.status != STATUS_WRITTEN, "fired flag on a write beat")

endmodule
